[hw/rtl/sclip_pkg.sv]
package sclip_pkg;

   localparam int ScrW      = 32;              // screen coordinate width
   localparam int PosW      = 24;              // normalized box position width
   localparam int BoxOne    = 65536;           // 1.0 in box position units
   localparam int BoxFrac   = 16;              // fraction bits of a box position
   localparam int NumFaces  = 6;
   localparam int NumW      = PosW;            // crossing fraction numerator / denominator
   localparam int ProdW     = ScrW + NumW;     // |delta| * numerator
   localparam int QuoW      = ScrW + 1;        // rounded quotient bits
   localparam int DivStages = QuoW + 1;        // divider depth, also the side-data delay line depth
   localparam int CntW      = 3;

   localparam int ReqDataW  = 336;
   localparam int RspDataW  = 200;
   localparam int RspUserW  = 2;

   typedef logic [ScrW-1:0] scr_type;
   typedef logic [PosW-1:0] pos_type;

   typedef struct packed {
      scr_type [2:0] sa;
      scr_type [2:0] sb;
      logic    [2:0] neg;
      logic          ia;
      logic          ib;
      logic [CntW-1:0] cnt;
      logic          s_has;
      logic          e_has;
   } side_type;

endpackage

[hw/rtl/segment_clip_unit_cube_unit.sv]
// Segment clip against the unit box, one segment per transaction.
// Request channel (req_): one segment, both endpoints with screen coordinates
// and normalized box positions. Response channel (rsp_): clipped start and
// end points, the crossing count, and the two inside flags in tuser.
// Every request gives exactly one response, in order; no state is kept
// between segments.
// Throughput: one segment per cycle while the receiver keeps rsp_tready high.
// The pipeline is capture, face setup, face-test products, face accept and
// endpoint select, delta product, a 34-stage bit-per-cycle divider for the
// rounded interpolation, and the output register; the divider sets depth.
// When the receiver holds rsp_tready low with a response pending, the whole
// pipeline holds and req_tready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline: all valid bits
// clear and rsp_tvalid is low in the cycle after reset.
module segment_clip_unit_cube_unit
   import sclip_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // ax, ay, az, au, av, aw, bx, by, bz, bu, bv, bw
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, crossings, zero fill
   output logic [RspDataW-1:0] rsp_tdata,
   // a_inside, b_inside
   output logic [RspUserW-1:0] rsp_tuser
);

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 1: capture
   logic    c1_v_ff;
   scr_type c1_sa_ff [3];
   scr_type c1_sb_ff [3];
   pos_type c1_pa_ff [3];
   pos_type c1_pb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) c1_v_ff <= 1'b0;
      else if (adv) c1_v_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            c1_sa_ff[k] <= req_tdata[ScrW*k +: ScrW];
            c1_pa_ff[k] <= req_tdata[3*ScrW + PosW*k +: PosW];
            c1_sb_ff[k] <= req_tdata[3*ScrW + 3*PosW + ScrW*k +: ScrW];
            c1_pb_ff[k] <= req_tdata[6*ScrW + 3*PosW + PosW*k +: PosW];
         end
      end
   end

   // ---------------- stage 2: inside tests and face setup
   logic ia_in, ib_in;

   always_comb begin
      ia_in = 1'b1;
      ib_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if ($signed(c1_pa_ff[k]) < 0 || $signed(c1_pa_ff[k]) > BoxOne) ia_in = 1'b0;
         if ($signed(c1_pb_ff[k]) < 0 || $signed(c1_pb_ff[k]) > BoxOne) ib_in = 1'b0;
      end
   end

   logic            f2_v_ff;
   logic            f2_ia_ff, f2_ib_ff;
   logic [NumFaces-1:0] f2_fv_ff, f2_ts_ff;
   logic [NumW-1:0] f2_num_ff [NumFaces];
   logic [NumW-1:0] f2_den_ff [NumFaces];
   scr_type         f2_sa_ff  [3];
   scr_type         f2_sb_ff  [3];
   pos_type         f2_pa_ff  [3];
   pos_type         f2_pb_ff  [3];

   for (genvar fi = 0; fi < NumFaces; fi++) begin : g_face
      localparam int K = fi / 2;
      localparam int F = fi % 2;
      logic signed [PosW:0] diff, nr, num_s, den_s;
      logic fv, ts;

      assign diff  = $signed({c1_pb_ff[K][PosW-1], c1_pb_ff[K]})
                   - $signed({c1_pa_ff[K][PosW-1], c1_pa_ff[K]});
      assign nr    = (F != 0 ? (PosW+1)'(BoxOne) : '0)
                   - $signed({c1_pa_ff[K][PosW-1], c1_pa_ff[K]});
      assign num_s = diff[PosW] ? -nr : nr;
      assign den_s = diff[PosW] ? -diff : diff;
      // skip faces parallel to the segment and crossings outside (0,1)
      assign fv    = !(ia_in && ib_in) && (diff != 0) && (num_s > 0) && (num_s < den_s);
      assign ts    = (F != 0) ? diff[PosW] : (diff > 0);

      always_ff @(posedge clock) begin
         if (adv) begin
            f2_fv_ff[fi]  <= fv;
            f2_ts_ff[fi]  <= ts;
            f2_num_ff[fi] <= num_s[NumW-1:0];
            f2_den_ff[fi] <= den_s[NumW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f2_v_ff <= 1'b0;
      else if (adv) f2_v_ff <= c1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_ia_ff <= ia_in;
         f2_ib_ff <= ib_in;
         f2_sa_ff <= c1_sa_ff;
         f2_sb_ff <= c1_sb_ff;
         f2_pa_ff <= c1_pa_ff;
         f2_pb_ff <= c1_pb_ff;
      end
   end

   // ---------------- stage 3: face-test products, delta magnitudes
   logic            p3_v_ff;
   logic            p3_ia_ff, p3_ib_ff;
   logic [NumFaces-1:0] p3_fv_ff, p3_ts_ff;
   logic [NumW-1:0] p3_num_ff [NumFaces];
   logic [NumW-1:0] p3_den_ff [NumFaces];
   logic signed [2*PosW:0]   p3_qa_ff [NumFaces][2];
   logic signed [2*PosW+1:0] p3_qb_ff [NumFaces][2];
   scr_type         p3_sa_ff  [3];
   scr_type         p3_sb_ff  [3];
   scr_type         p3_mag_ff [3];
   logic [2:0]      p3_neg_ff;

   for (genvar fi = 0; fi < NumFaces; fi++) begin : g_prod
      for (genvar j = 0; j < 2; j++) begin : g_other
         localparam int O = (fi / 2 + 1 + j) % 3;
         logic signed [PosW:0] dq;
         assign dq = $signed({f2_pb_ff[O][PosW-1], f2_pb_ff[O]})
                   - $signed({f2_pa_ff[O][PosW-1], f2_pa_ff[O]});
         always_ff @(posedge clock) begin
            if (adv) begin
               p3_qa_ff[fi][j] <= $signed(f2_pa_ff[O]) * $signed({1'b0, f2_den_ff[fi]});
               p3_qb_ff[fi][j] <= dq * $signed({1'b0, f2_num_ff[fi]});
            end
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_delta
      logic [ScrW:0] d;
      logic [ScrW:0] dn;
      assign d  = {f2_sb_ff[k][ScrW-1], f2_sb_ff[k]} - {f2_sa_ff[k][ScrW-1], f2_sa_ff[k]};
      assign dn = -d;
      always_ff @(posedge clock) begin
         if (adv) begin
            p3_neg_ff[k] <= d[ScrW];
            p3_mag_ff[k] <= d[ScrW] ? dn[ScrW-1:0] : d[ScrW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p3_v_ff <= 1'b0;
      else if (adv) p3_v_ff <= f2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_ia_ff  <= f2_ia_ff;
         p3_ib_ff  <= f2_ib_ff;
         p3_fv_ff  <= f2_fv_ff;
         p3_ts_ff  <= f2_ts_ff;
         p3_num_ff <= f2_num_ff;
         p3_den_ff <= f2_den_ff;
         p3_sa_ff  <= f2_sa_ff;
         p3_sb_ff  <= f2_sb_ff;
      end
   end

   // ---------------- stage 4: face accept, endpoint select
   localparam int TW = 2*PosW + 3;

   logic [NumFaces-1:0] acc;

   for (genvar fi = 0; fi < NumFaces; fi++) begin : g_acc
      logic [1:0] ok;
      for (genvar j = 0; j < 2; j++) begin : g_ok
         logic signed [TW-1:0] t;
         logic signed [TW-1:0] lim;
         assign t   = TW'(p3_qa_ff[fi][j]) + TW'(p3_qb_ff[fi][j]);
         assign lim = $signed({{(TW-NumW-BoxFrac){1'b0}}, p3_den_ff[fi], {BoxFrac{1'b0}}});
         assign ok[j] = !t[TW-1] && (t < lim);
      end
      assign acc[fi] = p3_fv_ff[fi] && ok[0] && ok[1];
   end

   logic            s_has, e_has;
   logic [NumW-1:0] s_num, s_den, e_num, e_den;

   // a later face overwrites an earlier one on the same endpoint
   always_comb begin
      s_has = 1'b0;
      e_has = 1'b0;
      s_num = '0;
      e_num = '0;
      s_den = NumW'(1);
      e_den = NumW'(1);
      for (int fi = 0; fi < NumFaces; fi++) begin
         if (acc[fi] && p3_ts_ff[fi]) begin
            s_has = 1'b1;
            s_num = p3_num_ff[fi];
            s_den = p3_den_ff[fi];
         end
         if (acc[fi] && !p3_ts_ff[fi]) begin
            e_has = 1'b1;
            e_num = p3_num_ff[fi];
            e_den = p3_den_ff[fi];
         end
      end
   end

   logic            s4_v_ff;
   side_type        s4_side_ff;
   logic [NumW-1:0] s4_num_ff [2];
   logic [NumW-1:0] s4_den_ff [2];
   scr_type         s4_mag_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (adv) s4_v_ff <= p3_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s4_side_ff.sa[k] <= p3_sa_ff[k];
            s4_side_ff.sb[k] <= p3_sb_ff[k];
         end
         s4_side_ff.neg   <= p3_neg_ff;
         s4_side_ff.ia    <= p3_ia_ff;
         s4_side_ff.ib    <= p3_ib_ff;
         s4_side_ff.cnt   <= CntW'($countones(acc));
         s4_side_ff.s_has <= s_has;
         s4_side_ff.e_has <= e_has;
         s4_num_ff[0]     <= s_num;
         s4_num_ff[1]     <= e_num;
         s4_den_ff[0]     <= s_den;
         s4_den_ff[1]     <= e_den;
         s4_mag_ff        <= p3_mag_ff;
      end
   end

   // ---------------- stage 5: |delta| * numerator
   logic            m5_v_ff;
   side_type        m5_side_ff;
   logic [ProdW-1:0] m5_prod_ff [2][3];
   logic [NumW-1:0] m5_den_ff [2];

   always_ff @(posedge clock) begin
      if (reset) m5_v_ff <= 1'b0;
      else if (adv) m5_v_ff <= s4_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m5_side_ff <= s4_side_ff;
         m5_den_ff  <= s4_den_ff;
         for (int e = 0; e < 2; e++) begin
            for (int k = 0; k < 3; k++) begin
               m5_prod_ff[e][k] <= {{NumW{1'b0}}, s4_mag_ff[k]} * {{ScrW{1'b0}}, s4_num_ff[e]};
            end
         end
      end
   end

   // ---------------- divider stages, side data travels alongside
   logic [QuoW-1:0] quo [2][3];

   for (genvar e = 0; e < 2; e++) begin : g_div_e
      for (genvar k = 0; k < 3; k++) begin : g_div_k
         sclip_div u_div (
            .clock (clock),
            .en    (adv),
            .prod  (m5_prod_ff[e][k]),
            .den   (m5_den_ff[e]),
            .quo   (quo[e][k])
         );
      end
   end

   logic     dv_v_ff    [DivStages];
   side_type dv_side_ff [DivStages];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivStages; i++) dv_v_ff[i] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= m5_v_ff;
         for (int i = 1; i < DivStages; i++) dv_v_ff[i] <= dv_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= m5_side_ff;
         for (int i = 1; i < DivStages; i++) dv_side_ff[i] <= dv_side_ff[i-1];
      end
   end

   // ---------------- output register
   side_type    last;
   scr_type     pt [2][3];
   logic [1:0]  has;

   assign last = dv_side_ff[DivStages-1];
   assign has  = {last.e_has, last.s_has};

   for (genvar e = 0; e < 2; e++) begin : g_out_e
      for (genvar k = 0; k < 3; k++) begin : g_out_k
         logic [QuoW:0] qs;
         logic [QuoW:0] c;
         assign qs = last.neg[k] ? -{1'b0, quo[e][k]} : {1'b0, quo[e][k]};
         assign c  = {{(QuoW+1-ScrW){last.sa[k][ScrW-1]}}, last.sa[k]} + qs;
         assign pt[e][k] = has[e] ? c[ScrW-1:0] : (e == 0 ? last.sa[k] : last.sb[k]);
      end
   end

   logic                rsp_v_ff;
   logic [RspDataW-1:0] rsp_data_ff;
   logic [RspUserW-1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (adv) rsp_v_ff <= dv_v_ff[DivStages-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {{(RspDataW-6*ScrW-CntW){1'b0}}, last.cnt,
                         pt[1][2], pt[1][1], pt[1][0], pt[0][2], pt[0][1], pt[0][0]};
         rsp_user_ff <= {last.ib, last.ia};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hw/rtl/sclip_div.sv]
module sclip_div
   import sclip_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [ProdW-1:0] prod,
   input  logic [NumW-1:0]  den,
   output logic [QuoW-1:0]  quo
);

   // quo = floor((2*prod + den) / (2*den)), one quotient bit per stage
   localparam int DivW = NumW + 1;
   localparam int NW   = ProdW + 2;

   logic [DivW-1:0] rem_ff [0:QuoW];
   logic [QuoW-1:0] low_ff [0:QuoW];
   logic [QuoW-1:0] q_ff   [0:QuoW];
   logic [DivW-1:0] dv_ff  [0:QuoW];
   logic [NW-1:0]   n_in;

   assign n_in = {1'b0, prod, 1'b0} + {{(NW-NumW){1'b0}}, den};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= n_in[NW-1:QuoW];
         low_ff[0] <= n_in[QuoW-1:0];
         q_ff[0]   <= '0;
         dv_ff[0]  <= {den, 1'b0};
      end
   end

   for (genvar i = 0; i < QuoW; i++) begin : g_step
      logic [DivW:0] trial;
      logic [DivW:0] diff;
      logic          ge;

      assign trial = {rem_ff[i], low_ff[i][QuoW-1]};
      assign diff  = trial - {1'b0, dv_ff[i]};
      assign ge    = (trial >= {1'b0, dv_ff[i]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
            low_ff[i+1] <= {low_ff[i][QuoW-2:0], 1'b0};
            q_ff[i+1]   <= {q_ff[i][QuoW-2:0], ge};
            dv_ff[i+1]  <= dv_ff[i];
         end
      end
   end

   assign quo = q_ff[QuoW];

endmodule

[hw/rtl/sclip_check.sv]
module sclip_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // with no pending response the block takes requests
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // both endpoints inside: no face is crossed
   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tuser[1] |-> rsp_tdata[194:192] == 3'd0)
      else $error("crossings reported for an inside segment");

   // at most six faces, checked only while a request is also valid
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && req_tvalid |-> rsp_tdata[194:192] != 3'd7)
      else $error("crossing count out of range");

endmodule

bind segment_clip_unit_cube_unit sclip_check u_sclip_check (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import sclip_pkg::*;

   typedef struct {
      logic signed [31:0] sx [3];
      logic signed [31:0] sy [3];
      logic signed [23:0] pa [3];
      logic signed [23:0] pb [3];
   } seg_type;

   typedef struct {
      logic               a_in;
      logic               b_in;
      logic signed [31:0] st [3];
      logic signed [31:0] en [3];
      logic [2:0]         cnt;
   } clip_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic [RspUserW-1:0] rsp_tuser;

   clip_type clip_queue [$];
   int       fail_count;
   bit       calm;
   bit       hold_long;

   segment_clip_unit_cube_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic pos_inside(logic signed [23:0] p [3]);
      for (int k = 0; k < 3; k++)
         if (p[k] < 0 || p[k] > BoxOne) return 1'b0;
      return 1'b1;
   endfunction

   function automatic longint round_scale(longint d, longint num, longint den);
      longint prod;
      longint mag;
      longint q;
      prod = d * num;
      mag = prod < 0 ? -prod : prod;
      q = (2 * mag + den) / (2 * den);
      return prod < 0 ? -q : q;
   endfunction

   function automatic logic frac_ok(longint q1, longint q2, longint num, longint den);
      longint t;
      t = q1 * den + (q2 - q1) * num;
      return t >= 0 && t < longint'(BoxOne) * den;
   endfunction

   function automatic clip_type clip_segment(seg_type s);
      clip_type r;
      longint   num, den, pos;
      int       o1, o2;
      logic     to_st;
      r.a_in = pos_inside(s.pa);
      r.b_in = pos_inside(s.pb);
      r.cnt = 0;
      for (int k = 0; k < 3; k++) begin
         r.st[k] = s.sx[k];
         r.en[k] = s.sy[k];
      end
      if (!(r.a_in && r.b_in)) begin
         for (int k = 0; k < 3; k++) begin
            o1 = (k + 1) % 3;
            o2 = (k + 2) % 3;
            for (int f = 0; f < 2; f++) begin
               pos = f ? BoxOne : 0;
               num = pos - s.pa[k];
               den = longint'(s.pb[k]) - s.pa[k];
               if (den == 0) continue;
               if (den < 0) begin
                  den = -den;
                  num = -num;
               end
               if (!(num > 0 && num < den)) continue;
               if (!frac_ok(s.pa[o1], s.pb[o1], num, den)) continue;
               if (!frac_ok(s.pa[o2], s.pb[o2], num, den)) continue;
               to_st = f ? (s.pa[k] > s.pb[k]) : (s.pa[k] < s.pb[k]);
               for (int j = 0; j < 3; j++) begin
                  if (to_st)
                     r.st[j] = s.sx[j] + round_scale(longint'(s.sy[j]) - s.sx[j], num, den);
                  else
                     r.en[j] = s.sx[j] + round_scale(longint'(s.sy[j]) - s.sx[j], num, den);
               end
               r.cnt++;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [ReqDataW-1:0] pack_segment(seg_type s);
      return {s.pb[2], s.pb[1], s.pb[0], s.sy[2], s.sy[1], s.sy[0],
              s.pa[2], s.pa[1], s.pa[0], s.sx[2], s.sx[1], s.sx[0]};
   endfunction

   function automatic logic signed [23:0] rand_pos(int mode);
      case (mode)
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, BoxOne));
         2: return 24'(int'($urandom_range(0, 3 * BoxOne)) - BoxOne);
         default: return 24'(BoxOne * int'($urandom_range(0, 1)));
      endcase
   endfunction

   function automatic seg_type rand_segment();
      seg_type s;
      int      mode;
      int      pk;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         s.sx[k] = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 65535));
         s.sy[k] = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 65535));
         s.pa[k] = rand_pos(mode == 0 ? 0 : (mode < 3 ? 1 : (mode == 9 ? 3 : 2)));
         s.pb[k] = rand_pos(mode == 0 ? 0 : (mode == 9 ? 3 : 2));
      end
      // share a coordinate now and then so faces lie parallel
      pk = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) s.pb[pk] = s.pa[pk];
      return s;
   endfunction

   task automatic send_segment(seg_type s, logic chk, clip_type want);
      clip_type got;
      got = clip_segment(s);
      if (chk && (got.a_in !== want.a_in || got.b_in !== want.b_in || got.cnt !== want.cnt
                  || got.st != want.st || got.en != want.en)) begin
         $display("%0t predictor disagrees with table row: expected cnt %0d actual %0d",
                  $time, want.cnt, got.cnt);
         fail_count++;
      end
      while (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_segment(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      clip_queue.push_back(got);
   endtask

   task automatic check_response();
      clip_type want;
      clip_type got;
      got.st[0] = rsp_tdata[31:0];
      got.st[1] = rsp_tdata[63:32];
      got.st[2] = rsp_tdata[95:64];
      got.en[0] = rsp_tdata[127:96];
      got.en[1] = rsp_tdata[159:128];
      got.en[2] = rsp_tdata[191:160];
      got.cnt   = rsp_tdata[194:192];
      got.a_in  = rsp_tuser[0];
      got.b_in  = rsp_tuser[1];
      if (clip_queue.size() == 0) begin
         $display("%0t unexpected response: expected none actual %h", $time, rsp_tdata);
         fail_count++;
         return;
      end
      want = clip_queue.pop_front();
      if (got.a_in !== want.a_in || got.b_in !== want.b_in) begin
         $display("%0t inside flags: expected %b%b actual %b%b", $time,
                  want.b_in, want.a_in, got.b_in, got.a_in);
         fail_count++;
      end
      if (got.cnt !== want.cnt) begin
         $display("%0t crossings: expected %0d actual %0d", $time, want.cnt, got.cnt);
         fail_count++;
      end
      for (int k = 0; k < 3; k++) begin
         if (got.st[k] !== want.st[k]) begin
            $display("%0t start[%0d]: expected %0d actual %0d", $time, k, want.st[k], got.st[k]);
            fail_count++;
         end
         if (got.en[k] !== want.en[k]) begin
            $display("%0t end[%0d]: expected %0d actual %0d", $time, k, want.en[k], got.en[k]);
            fail_count++;
         end
      end
   endtask

   // receiver: random stalls, one long hold-off early on
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_response();
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            if (rsp_tvalid && rsp_tready) check_response();
         end
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            if (rsp_tvalid && rsp_tready) check_response();
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      seg_type  s;
      clip_type w;
      int       timer;
      seg_type  rows [12];
      clip_type wants [12];
      logic     chk [12];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      fail_count = 0;
      calm       = 0;
      hold_long  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // table: rows with a hand-typed result carry chk
      for (int i = 0; i < 12; i++) begin
         for (int k = 0; k < 3; k++) begin
            rows[i].sx[k] = 32'(100 * (k + 1));
            rows[i].sy[k] = 32'(1000 * (k + 1));
            rows[i].pa[k] = BoxOne / 2;
            rows[i].pb[k] = BoxOne / 2;
            wants[i].st[k] = rows[i].sx[k];
            wants[i].en[k] = rows[i].sy[k];
         end
         wants[i].a_in = 1;
         wants[i].b_in = 1;
         wants[i].cnt = 0;
         chk[i] = 0;
      end
      chk[0] = 1;                                         // both inside, unchanged
      rows[1].pa = '{0, 0, 0};
      rows[1].pb = '{BoxOne, BoxOne, BoxOne};             // corners, still inside
      chk[1] = 1;
      rows[2].pa = '{-BoxOne, BoxOne / 2, BoxOne / 2};    // enters through u = 0
      rows[3].pb = '{2 * BoxOne, BoxOne / 2, BoxOne / 2}; // leaves through u = 1
      rows[4].pa = '{BoxOne / 2, -BoxOne, BoxOne / 2};
      rows[4].pb = '{BoxOne / 2, 2 * BoxOne, BoxOne / 2}; // both v faces
      rows[5].pa = '{BoxOne / 2, BoxOne / 2, 2 * BoxOne};
      rows[5].pb = '{BoxOne / 2, BoxOne / 2, -BoxOne};    // both w faces, falling
      rows[6].pa = '{-BoxOne, -BoxOne, -BoxOne};
      rows[6].pb = '{2 * BoxOne, 2 * BoxOne, 2 * BoxOne}; // through corners
      rows[7].pa = '{-BoxOne, 2 * BoxOne, BoxOne / 2};
      rows[7].pb = '{-BoxOne, -BoxOne, BoxOne / 2};       // parallel, outside
      rows[8].pa = '{-8388608, -8388608, -8388608};
      rows[8].pb = '{8388607, 8388607, 8388607};          // position extremes
      for (int k = 0; k < 3; k++) begin
         rows[8].sx[k] = 32'h8000_0000;
         rows[8].sy[k] = 32'h7fff_ffff;
         rows[9].sx[k] = 32'h7fff_ffff;
         rows[9].sy[k] = 32'h8000_0000;
         rows[10].sx[k] = 32'hffff_ffff;
      end
      rows[9].pa = '{8388607, -8388608, 0};
      rows[9].pb = '{-8388608, 8388607, BoxOne};
      rows[10].pa = '{BoxOne, BoxOne / 2, BoxOne / 2};
      rows[10].pb = '{BoxOne + 1, BoxOne / 2, BoxOne / 2}; // touches face at fr 0
      rows[11].pa = '{BoxOne / 2, BoxOne / 2, -1};
      rows[11].pb = '{BoxOne / 2, BoxOne, BoxOne / 2};     // leaves at v = 1 open bound
      for (int i = 0; i < 12; i++) send_segment(rows[i], chk[i], wants[i]);

      hold_long = 1;
      for (int i = 0; i < 1850; i++) begin
         if (i == 1650) calm = 1;
         s = rand_segment();
         send_segment(s, 0, w);
      end
      req_tvalid <= 1'b0;

      timer = 0;
      while (clip_queue.size() != 0 && timer < 100000) begin
         @(posedge clock);
         timer++;
      end
      repeat (60) @(posedge clock);
      if (clip_queue.size() != 0) begin
         $display("%0t responses missing: expected %0d more actual 0", $time, clip_queue.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
